### design/tmp_pkg.sv
// shared types and constants for the trapezoidal motion position block
package tmp_pkg;

  // divider: dividend, divisor and count widths
  localparam int DIV_W  = 66;
  localparam int DVS_W  = 33;
  localparam int DCNT_W = $clog2(DIV_W);

  // square root: radicand, root, partial remainder and count widths
  localparam int SQ_W   = 66;
  localparam int RT_W   = 33;
  localparam int SQ_RW  = 37;
  localparam int SCNT_W = $clog2(RT_W);

  // profile time width, Q16.16 with headroom for the summed segments
  localparam int TW = 50;

  // register indexes on the configuration port
  localparam logic [1:0] REG_DIST  = 2'd0;
  localparam logic [1:0] REG_ACCEL = 2'd1;
  localparam logic [1:0] REG_SPEED = 2'd2;
  localparam logic [1:0] REG_DECEL = 2'd3;

  // configuration registers
  typedef struct packed {
    logic [31:0] move_len;
    logic [31:0] accel;
    logic [31:0] speed;
    logic [31:0] decel;
  } cfg_t;

  // precomputed profile, stable while items flow
  typedef struct packed {
    logic          linear;
    logic          ramp_ok;
    logic [TW-1:0] ta;
    logic [TW-1:0] tam;
    logic [TW-1:0] total;
    logic [31:0]   ad;
    logic [31:0]   lin_end;
  } prof_t;

  // segment of the move that an item falls in
  typedef enum logic [2:0] {
    PH_ZERO,
    PH_LIN,
    PH_ACC,
    PH_CRU,
    PH_DEC,
    PH_END
  } phase_t;

  // profile sequencer states
  typedef enum logic [3:0] {
    PS_IDLE,
    PS_VSQ,
    PS_LIN,
    PS_TA,
    PS_AD,
    PS_TD,
    PS_DD,
    PS_CHK,
    PS_TRI,
    PS_TAR,
    PS_TAS,
    PS_TDR,
    PS_TDS,
    PS_MVT,
    PS_SUM
  } pstate_t;

endpackage

### design/tmp_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module tmp_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tmp_pkg::DIV_W-1:0]  dividend,
  input  logic [tmp_pkg::DVS_W-1:0]  divisor,
  output logic [tmp_pkg::DIV_W-1:0]  quotient,
  output logic                       done
);

  logic                        busy;
  logic [tmp_pkg::DCNT_W-1:0]  cnt;
  logic [tmp_pkg::DVS_W-1:0]   rem;
  logic [tmp_pkg::DVS_W-1:0]   dvs;
  logic [tmp_pkg::DIV_W-1:0]   quo;
  logic [tmp_pkg::DVS_W:0]     rem_sh;
  logic [tmp_pkg::DVS_W:0]     rem_sub;
  logic                        ge;
  logic [tmp_pkg::DVS_W-1:0]   rem_next;

  // one restoring step
  always_comb begin
    rem_sh   = {rem, quo[tmp_pkg::DIV_W-1]};
    rem_sub  = rem_sh - {1'b0, dvs};
    ge       = rem_sh >= {1'b0, dvs};
    rem_next = ge ? rem_sub[tmp_pkg::DVS_W-1:0] : rem_sh[tmp_pkg::DVS_W-1:0];
  end

  assign quotient = quo;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= tmp_pkg::DCNT_W'(tmp_pkg::DIV_W - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[tmp_pkg::DIV_W-2:0], ge};
    end
  end

endmodule

### design/tmp_isqrt.sv
// bit-serial integer square root, one root bit per cycle
module tmp_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [tmp_pkg::SQ_W-1:0]  radicand,
  output logic [tmp_pkg::RT_W-1:0]  root,
  output logic                      done
);

  logic                        busy;
  logic [tmp_pkg::SCNT_W-1:0]  cnt;
  logic [tmp_pkg::SQ_W-1:0]    rad;
  logic [tmp_pkg::RT_W-1:0]    res;
  logic [tmp_pkg::SQ_RW-1:0]   rem;
  logic [tmp_pkg::SQ_RW-1:0]   rem_sh;
  logic [tmp_pkg::SQ_RW-1:0]   trial;
  logic                        ge;

  // bring down two bits and try the next root bit
  always_comb begin
    rem_sh = {rem[tmp_pkg::SQ_RW-3:0], rad[tmp_pkg::SQ_W-1 -: 2]};
    trial  = {2'b00, res, 2'b01};
    ge     = rem_sh >= trial;
  end

  assign root = res;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= tmp_pkg::SCNT_W'(tmp_pkg::RT_W - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad <= radicand;
      res <= '0;
      rem <= '0;
    end else if (busy) begin
      rad <= {rad[tmp_pkg::SQ_W-3:0], 2'b00};
      rem <= ge ? rem_sh - trial : rem_sh;
      res <= {res[tmp_pkg::RT_W-2:0], ge};
    end
  end

endmodule

### design/tmp_prof.sv
// profile sequencer: ramp and cruise times worked out from the configuration
module tmp_prof (
  input  logic            clk,
  input  logic            rst,
  input  logic            restart,
  input  tmp_pkg::cfg_t   cfg,
  output tmp_pkg::prof_t  prof,
  output logic            busy
);

  tmp_pkg::pstate_t state, state_next;
  logic launched, launched_next;

  logic [63:0] vsq;
  logic [63:0] dr;
  logic [47:0] lin_end;
  logic [47:0] ta;
  logic [47:0] td;
  logic [63:0] ad;
  logic [63:0] dd;
  logic [47:0] mvt;
  logic [tmp_pkg::TW-1:0] tam;
  logic [tmp_pkg::TW-1:0] total;

  logic                       div_start;
  logic [tmp_pkg::DIV_W-1:0]  div_dvd;
  logic [tmp_pkg::DVS_W-1:0]  div_dvs;
  logic [tmp_pkg::DIV_W-1:0]  div_q;
  logic                       div_done;
  logic                       sq_start;
  logic [tmp_pkg::RT_W-1:0]   sq_root;
  logic                       sq_done;

  logic use_div, use_sq, skip, div_fin, sq_fin, tri_prof;
  logic a_nz, r_nz;
  logic [31:0] mvd;
  tmp_pkg::pstate_t after;

  tmp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .done     (div_done)
  );

  tmp_isqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (div_q),
    .root     (sq_root),
    .done     (sq_done)
  );

  assign a_nz     = cfg.accel != '0;
  assign r_nz     = cfg.decel != '0;
  assign tri_prof = ({1'b0, ad} + {1'b0, dd}) > 65'(cfg.move_len);
  assign mvd      = cfg.move_len - ad[31:0] - dd[31:0];

  // next state, unit operands and launches
  always_comb begin
    state_next    = state;
    launched_next = launched;
    div_start     = 1'b0;
    sq_start      = 1'b0;
    div_dvd       = '0;
    div_dvs       = '0;
    use_div       = 1'b0;
    use_sq        = 1'b0;
    skip          = 1'b0;
    after         = tmp_pkg::PS_IDLE;
    unique case (state)
      tmp_pkg::PS_IDLE: begin
      end
      tmp_pkg::PS_VSQ: begin
        state_next = tmp_pkg::PS_LIN;
      end
      tmp_pkg::PS_LIN: begin
        use_div = 1'b1;
        div_dvd = {18'b0, cfg.move_len, 16'b0};
        div_dvs = {1'b0, cfg.speed};
        after   = tmp_pkg::PS_TA;
      end
      tmp_pkg::PS_TA: begin
        use_div = 1'b1;
        skip    = !a_nz;
        div_dvd = {18'b0, cfg.speed, 16'b0};
        div_dvs = {1'b0, cfg.accel};
        after   = tmp_pkg::PS_AD;
      end
      tmp_pkg::PS_AD: begin
        use_div = 1'b1;
        skip    = !a_nz;
        div_dvd = {2'b0, vsq};
        div_dvs = {cfg.accel, 1'b0};
        after   = tmp_pkg::PS_TD;
      end
      tmp_pkg::PS_TD: begin
        use_div = 1'b1;
        skip    = !r_nz;
        div_dvd = {18'b0, cfg.speed, 16'b0};
        div_dvs = {1'b0, cfg.decel};
        after   = tmp_pkg::PS_DD;
      end
      tmp_pkg::PS_DD: begin
        use_div = 1'b1;
        skip    = !r_nz;
        div_dvd = {2'b0, vsq};
        div_dvs = {cfg.decel, 1'b0};
        after   = tmp_pkg::PS_CHK;
      end
      tmp_pkg::PS_CHK: begin
        if (!tri_prof) begin
          state_next = tmp_pkg::PS_MVT;
        end else if (a_nz && r_nz) begin
          state_next = tmp_pkg::PS_TRI;
        end else begin
          state_next = tmp_pkg::PS_TAR;
        end
      end
      tmp_pkg::PS_TRI: begin
        use_div = 1'b1;
        div_dvd = {2'b0, dr};
        div_dvs = {1'b0, cfg.accel} + {1'b0, cfg.decel};
        after   = tmp_pkg::PS_TAR;
      end
      tmp_pkg::PS_TAR: begin
        use_div = 1'b1;
        skip    = !a_nz;
        div_dvd = {1'b0, ad[31:0], 1'b0, 32'b0};
        div_dvs = {1'b0, cfg.accel};
        after   = tmp_pkg::PS_TAS;
      end
      tmp_pkg::PS_TAS: begin
        use_sq = 1'b1;
        after  = tmp_pkg::PS_TDR;
      end
      tmp_pkg::PS_TDR: begin
        use_div = 1'b1;
        skip    = !r_nz;
        div_dvd = {1'b0, dd[31:0], 1'b0, 32'b0};
        div_dvs = {1'b0, cfg.decel};
        after   = tmp_pkg::PS_TDS;
      end
      tmp_pkg::PS_TDS: begin
        use_sq = 1'b1;
        after  = tmp_pkg::PS_MVT;
      end
      tmp_pkg::PS_MVT: begin
        use_div = 1'b1;
        div_dvd = {18'b0, mvd, 16'b0};
        div_dvs = {1'b0, cfg.speed};
        after   = tmp_pkg::PS_SUM;
      end
      tmp_pkg::PS_SUM: begin
        state_next = tmp_pkg::PS_IDLE;
      end
      default: begin
        state_next = tmp_pkg::PS_IDLE;
      end
    endcase

    // shared launch and wait on the divider or the root unit
    if (use_div || use_sq) begin
      if (skip) begin
        state_next = (state == tmp_pkg::PS_TAR) ? tmp_pkg::PS_TDR :
                     (state == tmp_pkg::PS_TDR) ? tmp_pkg::PS_MVT : after;
      end else if (!launched) begin
        div_start     = use_div;
        sq_start      = use_sq;
        launched_next = 1'b1;
      end else if ((use_div && div_done) || (use_sq && sq_done)) begin
        launched_next = 1'b0;
        state_next    = after;
      end
    end
  end

  assign div_fin = use_div && launched && div_done;
  assign sq_fin  = use_sq && launched && sq_done;

  // state register
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state    <= tmp_pkg::PS_VSQ;
      launched <= 1'b0;
    end else begin
      state    <= state_next;
      launched <= launched_next;
    end
  end

  // profile values
  always_ff @(posedge clk) begin
    unique case (state)
      tmp_pkg::PS_VSQ: vsq <= 64'(cfg.speed) * 64'(cfg.speed);
      tmp_pkg::PS_LIN: if (div_fin) lin_end <= div_q[47:0];
      tmp_pkg::PS_TA: begin
        if (skip) ta <= '0;
        else if (div_fin) ta <= div_q[47:0];
      end
      tmp_pkg::PS_AD: begin
        if (skip) ad <= '0;
        else if (div_fin) ad <= div_q[63:0];
      end
      tmp_pkg::PS_TD: begin
        if (skip) td <= '0;
        else if (div_fin) td <= div_q[47:0];
      end
      tmp_pkg::PS_DD: begin
        if (skip) dd <= '0;
        else if (div_fin) dd <= div_q[63:0];
      end
      tmp_pkg::PS_CHK: begin
        dr <= 64'(cfg.move_len) * 64'(cfg.decel);
        if (tri_prof && !(a_nz && r_nz)) begin
          if (a_nz) begin
            ad <= 64'(cfg.move_len);
            dd <= '0;
          end else begin
            ad <= '0;
            dd <= 64'(cfg.move_len);
          end
        end
      end
      tmp_pkg::PS_TRI: begin
        if (div_fin) begin
          ad <= div_q[63:0];
          dd <= 64'(cfg.move_len) - div_q[63:0];
        end
      end
      tmp_pkg::PS_TAS: if (sq_fin) ta <= 48'(sq_root);
      tmp_pkg::PS_TDS: if (sq_fin) td <= 48'(sq_root);
      tmp_pkg::PS_MVT: if (div_fin) mvt <= div_q[47:0];
      tmp_pkg::PS_SUM: begin
        tam   <= tmp_pkg::TW'(ta) + tmp_pkg::TW'(mvt);
        total <= tmp_pkg::TW'(ta) + tmp_pkg::TW'(mvt) + tmp_pkg::TW'(td);
      end
      default: begin
      end
    endcase
  end

  // profile out
  always_comb begin
    prof.linear  = !a_nz && !r_nz;
    prof.ramp_ok = (cfg.speed != '0) && (cfg.move_len != '0);
    prof.ta      = tmp_pkg::TW'(ta);
    prof.tam     = tam;
    prof.total   = total;
    prof.ad      = ad[31:0];
    prof.lin_end = lin_end[31:0];
  end

  assign busy = state != tmp_pkg::PS_IDLE;

endmodule

### design/tmp_pipe.sv
// per-item pipeline: segment select, ramp and cruise products, final position
module tmp_pipe (
  input  logic            clk,
  input  logic            rst,
  input  logic            hold,
  input  tmp_pkg::cfg_t   cfg,
  input  tmp_pkg::prof_t  prof,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [31:0]     elapsed_time,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     position,
  output logic [31:0]     time_out,
  output logic            time_clamped
);

  logic en1, en2, en3, en4, en5, en6, en_o;
  logic v1, v2, v3, v4, v5, v6;

  // stage 1
  logic [31:0] t1;
  // stage 2
  tmp_pkg::phase_t ph2, ph2_next;
  logic [31:0] t2, rate2, rate2_next;
  logic [32:0] tt2;
  logic        big2;
  logic [30:0] mop2, mop2_next;
  // stage 3
  tmp_pkg::phase_t ph3;
  logic [31:0] t3, rate3;
  logic [32:0] tt3;
  logic        big3;
  logic [63:0] m3;
  logic [62:0] cm3;
  // stage 4
  tmp_pkg::phase_t ph4;
  logic [31:0] t4;
  logic [32:0] tt4;
  logic        big4, z4;
  logic [48:0] vr4;
  logic [47:0] cp4;
  // stage 5
  tmp_pkg::phase_t ph5;
  logic [31:0] t5;
  logic        tt32_5, big5, z5;
  logic [48:0] vr5;
  logic [47:0] cp5;
  logic [63:0] p0_5;
  logic [48:0] p1_5;
  // stage 6
  tmp_pkg::phase_t ph6;
  logic [31:0] t6;
  logic        big6, z6;
  logic [47:0] cp6;
  logic [82:0] prod6;

  logic [tmp_pkg::TW-1:0] tp, t_dec, t_cru, tt_full;
  logic        nonpos;
  logic [64:0] vsum;
  logic [31:0] ramp_d, cru_sat;
  logic [31:0] pos_next, tout_next;
  logic        clamp_next;

  // stage enables: a stage loads when empty or when its successor moves
  assign en_o = !out_valid || out_ready;
  assign en6  = !v6 || en_o;
  assign en5  = !v5 || en6;
  assign en4  = !v4 || en5;
  assign en3  = !v3 || en4;
  assign en2  = !v2 || en3;
  assign en1  = !v1 || en2;
  assign in_ready = en1 && !hold;

  // segment select and operand choice
  always_comb begin
    tp      = {19'b0, t1[30:0]};
    nonpos  = t1[31] || (t1 == '0);
    t_dec   = prof.total - tp;
    t_cru   = tp - prof.ta;
    priority if (prof.linear) begin
      ph2_next = nonpos ? tmp_pkg::PH_ZERO : tmp_pkg::PH_LIN;
    end else if (nonpos || !prof.ramp_ok) begin
      ph2_next = tmp_pkg::PH_ZERO;
    end else if (tp <= prof.ta) begin
      ph2_next = tmp_pkg::PH_ACC;
    end else if (tp <= prof.tam) begin
      ph2_next = tmp_pkg::PH_CRU;
    end else if (tp >= prof.total) begin
      ph2_next = tmp_pkg::PH_END;
    end else begin
      ph2_next = tmp_pkg::PH_DEC;
    end
    tt_full    = '0;
    mop2_next  = '0;
    rate2_next = cfg.accel;
    unique case (ph2_next)
      tmp_pkg::PH_ACC: tt_full = tp;
      tmp_pkg::PH_DEC: begin
        tt_full    = t_dec;
        rate2_next = cfg.decel;
      end
      tmp_pkg::PH_LIN: mop2_next = t1[30:0];
      tmp_pkg::PH_CRU: mop2_next = t_cru[30:0];
      default: begin
      end
    endcase
  end

  // first ramp product folded with its top bit
  assign vsum = {1'b0, m3} + (tt3[32] ? {1'b0, rate3, 32'b0} : 65'b0);

  // ramp distance saturated to the move length
  always_comb begin
    if (z6) begin
      ramp_d = '0;
    end else if (big6 || (prod6[82:64] != '0) ||
                 (prod6[63:17] > 47'(cfg.move_len))) begin
      ramp_d = cfg.move_len;
    end else begin
      ramp_d = prod6[48:17];
    end
    cru_sat = (cp6 > 48'(cfg.move_len)) ? cfg.move_len : cp6[31:0];
  end

  // result of the item
  always_comb begin
    pos_next   = '0;
    tout_next  = t6;
    clamp_next = 1'b0;
    unique case (ph6)
      tmp_pkg::PH_LIN: begin
        if (cp6 > 48'(cfg.move_len)) begin
          pos_next   = cfg.move_len;
          tout_next  = prof.lin_end;
          clamp_next = 1'b1;
        end else begin
          pos_next = cp6[31:0];
        end
      end
      tmp_pkg::PH_ACC: pos_next = ramp_d;
      tmp_pkg::PH_CRU: pos_next = cru_sat;
      tmp_pkg::PH_DEC: pos_next = cfg.move_len - ramp_d;
      tmp_pkg::PH_END: begin
        pos_next   = cfg.move_len;
        tout_next  = prof.total[31:0];
        clamp_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid && in_ready;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
      if (en_o) out_valid <= v6;
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    if (en1) begin
      t1 <= elapsed_time;
    end
    if (en2) begin
      ph2   <= ph2_next;
      t2    <= t1;
      rate2 <= rate2_next;
      tt2   <= tt_full[32:0];
      big2  <= tt_full[tmp_pkg::TW-1:33] != '0;
      mop2  <= mop2_next;
    end
    if (en3) begin
      ph3   <= ph2;
      t3    <= t2;
      rate3 <= rate2;
      tt3   <= tt2;
      big3  <= big2;
      m3    <= 64'(rate2) * 64'(tt2[31:0]);
      cm3   <= 63'(cfg.speed) * 63'(mop2);
    end
    if (en4) begin
      ph4  <= ph3;
      t4   <= t3;
      tt4  <= tt3;
      big4 <= big3;
      z4   <= (rate3 == '0) || ((tt3 == '0) && !big3);
      vr4  <= vsum[64:16];
      cp4  <= ((ph3 == tmp_pkg::PH_CRU) ? 48'(prof.ad) : 48'b0) + 48'(cm3[62:16]);
    end
    if (en5) begin
      ph5    <= ph4;
      t5     <= t4;
      tt32_5 <= tt4[32];
      big5   <= big4;
      z5     <= z4;
      vr5    <= vr4;
      cp5    <= cp4;
      p0_5   <= 64'(vr4[31:0]) * 64'(tt4[31:0]);
      p1_5   <= 49'(vr4[48:32]) * 49'(tt4[31:0]);
    end
    if (en6) begin
      ph6   <= ph5;
      t6    <= t5;
      big6  <= big5;
      z6    <= z5;
      cp6   <= cp5;
      prod6 <= 83'(p0_5) + {2'b0, p1_5, 32'b0} +
               (tt32_5 ? {2'b0, vr5, 32'b0} : 83'b0);
    end
    if (en_o && v6) begin
      position     <= pos_next;
      time_out     <= tout_next;
      time_clamped <= clamp_next;
    end
  end

endmodule

### design/trapezoid_motion_position.sv
// Trapezoidal motion position: takes a signed Q16.16 elapsed time and returns the
// unsigned Q16.16 position along a move with acceleration, cruise and deceleration
// segments, together with the time used and a flag when that time was clamped to the
// move's end. The item datapath is a seven-stage pipeline that accepts one item every
// cycle while no output stall, configuration write or sequencer run holds it, and stalls
// on the output hold every stage without loss. After reset and after every configuration
// write the ramp, cruise and end times are worked out again by a sequencer around a
// shared bit-serial divider (one quotient bit per cycle, 66 steps per division) and a
// bit-serial square root, and in_ready stays low meanwhile. Configuration reads and
// writes are taken as ever.
module trapezoid_motion_position (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] elapsed_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        position,
  output logic signed [31:0] time_out,
  output logic               time_clamped
);

  tmp_pkg::cfg_t  cfg;
  tmp_pkg::prof_t prof;
  logic           wr;
  logic           busy;
  logic [31:0]    tout;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.move_len <= 32'h0001_0000;
      cfg.accel    <= '0;
      cfg.speed    <= 32'h0001_0000;
      cfg.decel    <= '0;
    end else if (wr) begin
      unique case (paddr[3:2])
        tmp_pkg::REG_DIST:  cfg.move_len <= pwdata;
        tmp_pkg::REG_ACCEL: cfg.accel    <= pwdata;
        tmp_pkg::REG_SPEED: cfg.speed    <= pwdata;
        tmp_pkg::REG_DECEL: cfg.decel    <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[3:2])
      tmp_pkg::REG_DIST:  prdata = cfg.move_len;
      tmp_pkg::REG_ACCEL: prdata = cfg.accel;
      tmp_pkg::REG_SPEED: prdata = cfg.speed;
      tmp_pkg::REG_DECEL: prdata = cfg.decel;
      default:            prdata = '0;
    endcase
  end

  tmp_prof u_prof (
    .clk     (clk),
    .rst     (rst),
    .restart (wr),
    .cfg     (cfg),
    .prof    (prof),
    .busy    (busy)
  );

  tmp_pipe u_pipe (
    .clk          (clk),
    .rst          (rst),
    .hold         (busy || wr),
    .cfg          (cfg),
    .prof         (prof),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .elapsed_time (elapsed_time),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .position     (position),
    .time_out     (tout),
    .time_clamped (time_clamped)
  );

  assign time_out = $signed(tout);

endmodule

### tb/sv/tb_trapezoid_motion_position.sv
// testbench for the trapezoidal motion position block: directed table, random items, predictor
module tb_trapezoid_motion_position;
  timeunit 1ns;
  timeprecision 1ps;

  // item and result types
  typedef struct packed {
    logic [31:0] pos;
    logic [31:0] tout;
    logic        clamp;
  } motion_res_t;

  typedef struct {
    logic [31:0] t;
    logic        has_exp;
    motion_res_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] elapsed_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] position;
  logic signed [31:0] time_out;
  logic time_clamped;

  trapezoid_motion_position u_top (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor's copy of the configuration
  logic [31:0] cfg_dist = 32'h0001_0000, cfg_accel = '0;
  logic [31:0] cfg_speed = 32'h0001_0000, cfg_decel = '0;

  motion_res_t pending_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit recv_hold = 1'b0;

  // distance covered from rest at a given rate after time tt, capped
  function automatic logic [63:0] ramp_dist(logic [63:0] rate, logic [63:0] tt,
                                            logic [63:0] cap);
    logic [63:0] v, d;
    if (rate == 0 || tt == 0) return 0;
    if (tt >= 64'h2_0000_0000) return cap;
    v = rate * (tt >> 16) + ((rate * (tt & 64'hFFFF)) >> 16);
    if (v > 64'hFFFF_FFFF_FFFF_FFFF / tt) return cap;
    d = (v * tt) >> 17;
    return (d > cap) ? cap : d;
  endfunction

  // time to cover distance d from rest at rate a, exact integer root
  function automatic logic [63:0] ramp_dur(logic [63:0] d, logic [63:0] a);
    logic [127:0] rad;
    logic [63:0] n, q1, r1, root, rem, trial;
    n = d << 1;
    q1 = n / a;
    r1 = n % a;
    rad = {q1, 32'h0} | ((r1 << 32) / a);
    root = 0;
    rem = 0;
    for (int k = 32; k >= 0; k--) begin
      rem = (rem << 2) | 64'(rad[2*k +: 2]);
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // position along the move for one elapsed time
  function automatic motion_res_t motion_at(logic [31:0] traw);
    motion_res_t r;
    logic nonpos;
    logic [63:0] t, dd_, a, v, rr, pos, tout, ta, ad, td, dd, mvd, mvt, total;
    nonpos = traw[31] || traw == 0;
    t = traw;
    dd_ = cfg_dist; a = cfg_accel; v = cfg_speed; rr = cfg_decel;
    pos = 0; tout = traw; r.clamp = 1'b0;
    if (a == 0 && rr == 0) begin
      if (!nonpos) begin
        pos = (v * t) >> 16;
        if (pos > dd_) begin
          tout = (dd_ << 16) / v;
          r.clamp = 1'b1;
          pos = dd_;
        end
      end
    end else if (!(nonpos || v == 0 || dd_ == 0)) begin
      ta = 0; ad = 0; td = 0; dd = 0;
      if (a != 0) begin
        ta = (v << 16) / a;
        ad = (v * v) / (2 * a);
      end
      if (rr != 0) begin
        td = (v << 16) / rr;
        dd = (v * v) / (2 * rr);
      end
      if (ad + dd > dd_) begin
        if (a != 0 && rr != 0) begin
          ad = (dd_ * rr) / (a + rr);
          dd = dd_ - ad;
        end else if (a != 0) begin
          ad = dd_; dd = 0;
        end else begin
          ad = 0; dd = dd_;
        end
        if (a != 0) ta = ramp_dur(ad, a);
        if (rr != 0) td = ramp_dur(dd, rr);
      end
      mvd = dd_ - (ad + dd);
      mvt = (mvd << 16) / v;
      total = ta + mvt + td;
      if (t <= ta) begin
        pos = ramp_dist(a, t, dd_);
      end else if (t <= ta + mvt) begin
        pos = ad + (((t - ta) * v) >> 16);
        if (pos > dd_) pos = dd_;
      end else if (t >= total) begin
        tout = total;
        r.clamp = 1'b1;
        pos = dd_;
      end else begin
        pos = dd_ - ramp_dist(rr, total - t, dd_);
      end
    end
    r.pos = pos[31:0];
    r.tout = tout[31:0];
    return r;
  endfunction

  // result checker and watchdog
  always @(posedge clk) begin
    motion_res_t e;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("DONE: errors detected");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result pos=%h", position);
        end else begin
          e = pending_q.pop_front();
          if (e.pos !== position || e.tout !== time_out || e.clamp !== time_clamped) begin
            errors++;
            if (errors <= 10)
              $display("mismatch exp pos=%h t=%h c=%b got pos=%h t=%h c=%b",
                       e.pos, e.tout, e.clamp, position, time_out, time_clamped);
          end
        end
      end
    end
  end

  // receiver readiness
  always @(posedge clk) begin
    if (rst || recv_hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // register write through setup and access cycles
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      tmp_pkg::REG_DIST:  cfg_dist = val;
      tmp_pkg::REG_ACCEL: cfg_accel = val;
      tmp_pkg::REG_SPEED: cfg_speed = val;
      default:            cfg_decel = val;
    endcase
  endtask

  // send one item, holding valid until taken
  task automatic send_time(logic [31:0] t, bit has_exp, motion_res_t exp_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    elapsed_time <= t;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(has_exp ? exp_res : motion_at(t));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // random time: spread over move, extremes and noise
  function automatic logic [31:0] rand_time();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'h8000_0000 | $urandom_range(3);
      2: return $urandom_range(16);
      default: return $urandom_range(32'h0040_0000);
    endcase
  endfunction

  task automatic random_phase(int n);
    motion_res_t dummy;
    dummy = '0;
    for (int i = 0; i < n; i++) send_time(rand_time(), 1'b0, dummy);
  endtask

  stim_row_t dir_rows[$];

  initial begin
    motion_res_t none;
    none = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset setting is linear at unit speed over unit distance
    dir_rows.push_back('{32'h0000_0000, 1'b1, '{32'h0, 32'h0000_0000, 1'b0}});
    dir_rows.push_back('{32'h8000_0000, 1'b1, '{32'h0, 32'h8000_0000, 1'b0}});
    dir_rows.push_back('{32'hFFFF_FFFF, 1'b1, '{32'h0, 32'hFFFF_FFFF, 1'b0}});
    dir_rows.push_back('{32'h0000_8000, 1'b1, '{32'h8000, 32'h0000_8000, 1'b0}});
    dir_rows.push_back('{32'h0001_0000, 1'b1, '{32'h1_0000, 32'h0001_0000, 1'b0}});
    dir_rows.push_back('{32'h7FFF_FFFF, 1'b1, '{32'h1_0000, 32'h0001_0000, 1'b1}});
    dir_rows.push_back('{32'h0000_0001, 1'b0, none});
    foreach (dir_rows[i]) send_time(dir_rows[i].t, dir_rows[i].has_exp, dir_rows[i].res);
    drain();

    // trapezoid, triangle, single ramp, zero speed and zero distance
    write_reg(tmp_pkg::REG_DIST, 32'h0004_0000);
    write_reg(tmp_pkg::REG_ACCEL, 32'h0002_0000);
    write_reg(tmp_pkg::REG_SPEED, 32'h0002_0000);
    write_reg(tmp_pkg::REG_DECEL, 32'h0001_0000);
    foreach (dir_rows[i]) send_time(dir_rows[i].t, 1'b0, none);
    send_time(32'h0001_8000, 1'b0, none); send_time(32'h0003_0000, 1'b0, none);
    drain();
    write_reg(tmp_pkg::REG_SPEED, 32'hFFFF_FFFF);
    send_time(32'h0000_8000, 1'b0, none); send_time(32'h0002_0000, 1'b0, none);
    drain();
    write_reg(tmp_pkg::REG_DECEL, 32'h0);
    send_time(32'h0000_C000, 1'b0, none); send_time(32'h7FFF_FFFF, 1'b0, none);
    drain();
    write_reg(tmp_pkg::REG_SPEED, 32'h0);
    send_time(32'h0001_0000, 1'b0, none);
    drain();
    write_reg(tmp_pkg::REG_SPEED, 32'h0001_0000); write_reg(tmp_pkg::REG_DIST, 32'h0);
    send_time(32'h0001_0000, 1'b0, none);
    drain();

    // extreme and random settings under three idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 23 : (ph < 4) ? 71 : 0;
      recv_idle_pct = (ph < 2) ? 71 : (ph < 4) ? 23 : 0;
      case (ph)
        0: begin
          write_reg(tmp_pkg::REG_DIST, 32'hFFFF_FFFF);
          write_reg(tmp_pkg::REG_ACCEL, 32'hFFFF_FFFF);
          write_reg(tmp_pkg::REG_SPEED, 32'hFFFF_FFFF);
          write_reg(tmp_pkg::REG_DECEL, 32'hFFFF_FFFF);
        end
        1: begin
          write_reg(tmp_pkg::REG_DIST, 32'h0000_0001);
          write_reg(tmp_pkg::REG_ACCEL, 32'h0000_0001);
          write_reg(tmp_pkg::REG_SPEED, 32'h0000_0001);
          write_reg(tmp_pkg::REG_DECEL, 32'h0000_0001);
        end
        default: begin
          write_reg(tmp_pkg::REG_DIST, $urandom_range(32'h0008_0000));
          write_reg(tmp_pkg::REG_ACCEL,
                    ($urandom_range(3) == 0) ? 0 : $urandom_range(32'h0004_0000));
          write_reg(tmp_pkg::REG_SPEED, $urandom_range(32'h0004_0000));
          write_reg(tmp_pkg::REG_DECEL,
                    ($urandom_range(3) == 0) ? 0 : $urandom_range(32'h0004_0000));
        end
      endcase
      if (ph == 4) begin
        // long output stall while items keep coming
        fork
          begin
            recv_hold = 1'b1;
            repeat (200) @(posedge clk);
            recv_hold = 1'b0;
          end
          random_phase(100);
        join
      end else begin
        random_phase(100);
      end
      drain();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
